// File: rtl/ovn_pkg.sv
package ovn_pkg;

  // Q1.16 one, also the top of the lattice value range
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // lattice hash constants
  localparam logic [31:0] HASH_MUL_Y = 32'd57;
  localparam int          HASH_SHIFT = 13;
  localparam logic [31:0] HASH_C1    = 32'd15731;
  localparam logic [31:0] HASH_C2    = 32'd789221;
  localparam logic [31:0] HASH_C3    = 32'd1376312589;

  typedef logic [16:0] unorm_t;   // Q1.16, 0..65536
  typedef logic [31:0] cell_t;    // wrapping lattice coordinate
  typedef logic [15:0] frac_t;    // Q0.16 fraction

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_PERSISTENCE  = 1'b0,
    CFG_OCTAVE_COUNT = 1'b1
  } cfg_idx_t;

  // (a*(1-f) + b*f) >> 16, floor
  function automatic unorm_t blend(input unorm_t a, input unorm_t b, input frac_t f);
    logic [33:0] pa;
    logic [33:0] pb;
    logic [34:0] s;
    pa = 34'(a) * 34'(ONE_Q16 - 17'(f));
    pb = 34'(b) * 34'(f);
    s  = 35'(pa) + 35'(pb);
    return s[32:16];
  endfunction

endpackage

// File: rtl/ovn_in_if.sv
interface ovn_in_if #(
  parameter int COORD_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

// File: rtl/ovn_out_if.sv
interface ovn_out_if ();
  logic        valid;
  logic        ready;
  logic [16:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

// File: rtl/ovn_hash.sv
// Five-stage lattice hash: coordinates in, Q1.16 lattice value out.
module ovn_hash import ovn_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  cell_t  cx,
  input  cell_t  cy,
  output unorm_t lat
);

  cell_t  n_sum;
  cell_t  n0_nxt;
  cell_t  n1_r, n2_r, n3_r;
  cell_t  sq_r, poly_r, mix_r;
  unorm_t lat_r;

  // fold the two coordinates and scramble
  always_comb begin
    n_sum  = 32'(cx + 32'(cy * HASH_MUL_Y));
    n0_nxt = (n_sum << HASH_SHIFT) ^ n_sum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r   <= n0_nxt;
      sq_r   <= 32'(n1_r * n1_r);
      n2_r   <= n1_r;
      poly_r <= 32'(32'(sq_r * HASH_C1) + HASH_C2);
      n3_r   <= n2_r;
      mix_r  <= 32'(32'(n3_r * poly_r) + HASH_C3);
      lat_r  <= ONE_Q16 - 17'(mix_r[30:15]);
    end
  end

  assign lat = lat_r;

endmodule

// File: rtl/ovn_octave.sv
// One octave: cell split, 4x4 lattice hashes, 3x3 smoothing, bilinear blend.
// Nine register stages from magnitudes to octave value.
module ovn_octave import ovn_pkg::*; #(
  parameter int OCT_IDX    = 0,
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 12
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [COORD_BITS-1:0] mx,
  input  logic [COORD_BITS-1:0] my,
  output unorm_t                value
);

  localparam int FDLY = 8;

  logic [63:0] sx, sy;
  cell_t       cx_r, cy_r;
  frac_t       fx_d_r [FDLY];
  frac_t       fy_d_r [FDLY];
  unorm_t      lat    [4][4];
  unorm_t      sm_nxt [4];
  unorm_t      sm_r   [4];
  unorm_t      i1_r, i2_r, val_r;

  // scale by 2^i, split into cell and fraction
  always_comb begin
    sx = 64'(mx) << OCT_IDX;
    sy = 64'(my) << OCT_IDX;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r      <= sx[FRAC_BITS +: 32];
      cy_r      <= sy[FRAC_BITS +: 32];
      fx_d_r[0] <= frac_t'(16'(sx[FRAC_BITS-1:0]) << (16 - FRAC_BITS));
      fy_d_r[0] <= frac_t'(16'(sy[FRAC_BITS-1:0]) << (16 - FRAC_BITS));
      for (int k = 1; k < FDLY; k++) begin
        fx_d_r[k] <= fx_d_r[k-1];
        fy_d_r[k] <= fy_d_r[k-1];
      end
    end
  end

  // lattice points at offsets -1..2 around the cell
  for (genvar gy = 0; gy < 4; gy++) begin : g_row
    for (genvar gx = 0; gx < 4; gx++) begin : g_col
      ovn_hash u_hash (
        .clk (clk),
        .en  (en),
        .cx  (32'(cx_r + 32'(gx) - 32'd1)),
        .cy  (32'(cy_r + 32'(gy) - 32'd1)),
        .lat (lat[gy][gx])
      );
    end
  end

  // 3x3 smoothing for the four corners of the cell
  for (genvar p = 0; p < 4; p++) begin : g_smooth
    localparam int PX = p % 2;
    localparam int PY = p / 2;
    logic [20:0] acc;
    always_comb begin
      acc = 21'(lat[PY][PX]) + 21'(lat[PY][PX+2]) + 21'(lat[PY+2][PX])
          + 21'(lat[PY+2][PX+2])
          + ((21'(lat[PY+1][PX]) + 21'(lat[PY+1][PX+2]) + 21'(lat[PY][PX+1])
              + 21'(lat[PY+2][PX+1])) << 1)
          + (21'(lat[PY+1][PX+1]) << 2);
      sm_nxt[p] = acc[20:4];
    end
  end

  // smooth, blend along x, blend along y
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) sm_r[k] <= sm_nxt[k];
      i1_r  <= blend(sm_r[0], sm_r[1], fx_d_r[6]);
      i2_r  <= blend(sm_r[2], sm_r[3], fx_d_r[6]);
      val_r <= blend(i1_r, i2_r, fy_d_r[7]);
    end
  end

  assign value = val_r;

endmodule

// File: rtl/ovn_weight.sv
// Octave amplitudes from the persistence register, masked by the octave
// count, and their sum. Free-running; after a register write it settles
// through the amplitude chain, the masked amplitudes and the sum register.
module ovn_weight import ovn_pkg::*; #(
  parameter int MAX_OCTAVES = 8,
  parameter int WW          = 20
) (
  input  logic          clk,
  input  logic [15:0]   persistence,
  input  logic [3:0]    octave_count,
  output unorm_t        amp [MAX_OCTAVES],
  output logic [WW-1:0] weight
);

  unorm_t        amp_r  [MAX_OCTAVES];
  unorm_t        used_r [MAX_OCTAVES];
  logic [4:0]    cnt;
  logic [WW-1:0] wsum;

  // effective octave count: zero means one, saturate at the maximum
  always_comb begin
    if (octave_count == 4'd0) begin
      cnt = 5'd1;
    end else if (5'(octave_count) > 5'(MAX_OCTAVES)) begin
      cnt = 5'(MAX_OCTAVES);
    end else begin
      cnt = 5'(octave_count);
    end
  end

  always_comb begin
    wsum = '0;
    for (int k = 0; k < MAX_OCTAVES; k++) wsum = WW'(wsum + WW'(used_r[k]));
  end

  // amplitude chain, one multiply per register
  always_ff @(posedge clk) begin
    amp_r[0] <= ONE_Q16;
    for (int k = 1; k < MAX_OCTAVES; k++) begin
      amp_r[k] <= 17'((33'(amp_r[k-1]) * 33'(persistence)) >> 16);
    end
    for (int k = 0; k < MAX_OCTAVES; k++) begin
      used_r[k] <= (5'(k) < cnt) ? amp_r[k] : '0;
    end
    weight <= wsum;
  end

  assign amp = used_r;

endmodule

// File: rtl/ovn_div.sv
// Restoring divider, one quotient bit per stage, 17 stages.
// The quotient is known to stay below 2^17.
module ovn_div import ovn_pkg::*; #(
  parameter int TOT_W = 37,
  parameter int WW    = 20
) (
  input  logic             clk,
  input  logic             en,
  input  logic [TOT_W-1:0] total,
  input  logic [WW-1:0]    weight,
  output logic [16:0]      quot
);

  localparam int QB = 17;

  logic [TOT_W-1:0] rem_r [QB];
  logic [WW-1:0]    w_r   [QB];
  logic [QB-1:0]    q_r   [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int K = QB - 1 - s;
    logic [TOT_W-1:0] rem_in;
    logic [WW-1:0]    w_in;
    logic [QB-1:0]    q_in;
    logic [TOT_W-1:0] trial;

    if (s == 0) begin : g_first
      assign rem_in = total;
      assign w_in   = weight;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign w_in   = w_r[s-1];
      assign q_in   = q_r[s-1];
    end

    assign trial = TOT_W'(w_in) << K;

    // subtract the shifted divisor where it fits
    always_ff @(posedge clk) begin
      if (en) begin
        w_r[s] <= w_in;
        if (rem_in >= trial) begin
          rem_r[s] <= rem_in - trial;
          q_r[s]   <= q_in | (QB'(1) << K);
        end else begin
          rem_r[s] <= rem_in;
          q_r[s]   <= q_in;
        end
      end
    end
  end

  assign quot = q_r[QB-1];

endmodule

// File: rtl/octave_value_noise_2d.sv
// Octave-summed 2D value noise. Each input item is a signed Q12.12 point;
// the result item is the normalized noise in unsigned Q1.16 (0..65536).
// Fully pipelined: a new item is taken every cycle unless the output stalls,
// and each result passes through the octave datapath (cell split, 5-stage
// lattice hash, smoothing, two blends), the weighting and sum stages and the
// 17-stage divider. Every octave has its own datapath with sixteen lattice
// hashes. A stall at the output freezes the whole pipeline. After a write to
// persistence or octave_count, allow the amplitude chain to settle before the
// next item.
module octave_value_noise_2d import ovn_pkg::*; #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 12,
  parameter int COORD_BITS  = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  ovn_in_if.sink          in_ch,
  ovn_out_if.source       out_ch,
  input  logic            cfg_we,
  input  cfg_idx_t        cfg_index,
  input  logic [15:0]     cfg_data
);

  localparam int LAT   = 30;
  localparam int CW    = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
  localparam int WW    = 17 + CW;
  localparam int TOT_W = 34 + CW;

  logic                  adv;
  logic [LAT-1:0]        vld_r;
  logic [15:0]           persistence_r;
  logic [3:0]            octave_count_r;
  logic [COORD_BITS-1:0] mx_r, my_r;
  unorm_t                oct_val [MAX_OCTAVES];
  unorm_t                amp     [MAX_OCTAVES];
  logic [WW-1:0]         weight;
  logic [33:0]           prod_r  [MAX_OCTAVES];
  logic [TOT_W-1:0]      total_nxt;
  logic [TOT_W-1:0]      total_r;
  logic [WW-1:0]         weight_r;
  logic [16:0]           quot;
  logic [16:0]           out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      persistence_r  <= 16'd32768;
      octave_count_r <= 4'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERSISTENCE:  persistence_r  <= cfg_data;
        CFG_OCTAVE_COUNT: octave_count_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output holds an untaken item
  assign adv         = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // coordinate magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r <= in_ch.pos_x[COORD_BITS-1] ? COORD_BITS'(~in_ch.pos_x + 1'b1)
                                        : COORD_BITS'(in_ch.pos_x);
      my_r <= in_ch.pos_y[COORD_BITS-1] ? COORD_BITS'(~in_ch.pos_y + 1'b1)
                                        : COORD_BITS'(in_ch.pos_y);
    end
  end

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    ovn_octave #(
      .OCT_IDX    (i),
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_octave (
      .clk   (clk),
      .en    (adv),
      .mx    (mx_r),
      .my    (my_r),
      .value (oct_val[i])
    );
  end

  ovn_weight #(
    .MAX_OCTAVES (MAX_OCTAVES),
    .WW          (WW)
  ) u_weight (
    .clk          (clk),
    .persistence  (persistence_r),
    .octave_count (octave_count_r),
    .amp          (amp),
    .weight       (weight)
  );

  // weighted sum of the octaves
  always_comb begin
    total_nxt = '0;
    for (int k = 0; k < MAX_OCTAVES; k++) total_nxt = TOT_W'(total_nxt + TOT_W'(prod_r[k]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < MAX_OCTAVES; k++) prod_r[k] <= 34'(oct_val[k]) * 34'(amp[k]);
      total_r  <= total_nxt;
      weight_r <= weight;
    end
  end

  ovn_div #(
    .TOT_W (TOT_W),
    .WW    (WW)
  ) u_div (
    .clk    (clk),
    .en     (adv),
    .total  (total_r),
    .weight (weight_r),
    .quot   (quot)
  );

  // clamp and hold the result
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= (quot > ONE_Q16) ? ONE_Q16 : quot;
    end
  end

  assign out_ch.valid       = vld_r[LAT-1];
  assign out_ch.noise_value = out_r;

endmodule

// File: tb/octave_value_noise_2d_tb.sv
`timescale 1ns / 100ps

module octave_value_noise_2d_tb import ovn_pkg::*; ();

  localparam int MAX_OCT    = 8;
  localparam int FRAC_W     = 12;
  localparam int COORD_W    = 24;
  localparam int LATENCY    = 30;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [15:0] cfg_data;

  ovn_in_if #(.COORD_BITS(COORD_W)) in_ch ();
  ovn_out_if out_ch ();

  octave_value_noise_2d #(
    .MAX_OCTAVES(MAX_OCT),
    .FRAC_BITS  (FRAC_W),
    .COORD_BITS (COORD_W)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // shadow copy of the configuration registers
  logic [15:0] persist_q16;
  logic [3:0]  octaves;

  point_t      pending_pts[$];
  logic [16:0] expected_noise[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          mismatches;
  int          cycles;
  int          accepted_pts;
  logic        in_taken;

  // lattice hash to Q1.16, 1..65536
  function automatic logic [31:0] lattice_val(input logic [31:0] cx, input logic [31:0] cy);
    logic [31:0] n;
    logic [31:0] m;
    n = cx + cy * 32'd57;
    n = (n << 13) ^ n;
    m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
    return 32'd65536 - (m >> 15);
  endfunction

  // 3x3 weighted smoothing around a lattice point
  function automatic logic [31:0] smooth_val(input logic [31:0] cx, input logic [31:0] cy);
    logic [31:0] crn;
    logic [31:0] sds;
    crn = lattice_val(cx - 1, cy - 1) + lattice_val(cx + 1, cy - 1)
        + lattice_val(cx - 1, cy + 1) + lattice_val(cx + 1, cy + 1);
    sds = lattice_val(cx - 1, cy) + lattice_val(cx + 1, cy)
        + lattice_val(cx, cy - 1) + lattice_val(cx, cy + 1);
    return (crn + 2 * sds + 4 * lattice_val(cx, cy)) >> 4;
  endfunction

  function automatic logic [31:0] lerp16(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] f);
    logic [63:0] s;
    s = 64'(a) * 64'(32'd65536 - f) + 64'(b) * 64'(f);
    return 32'(s >> 16);
  endfunction

  function automatic logic [31:0] octave_noise(input logic [63:0] mx, input logic [63:0] my,
                                               input int oct);
    logic [63:0] sx;
    logic [63:0] sy;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] fx;
    logic [31:0] fy;
    sx = mx << oct;
    sy = my << oct;
    cx = 32'(sx >> FRAC_W);
    cy = 32'(sy >> FRAC_W);
    fx = 32'(sx[FRAC_W-1:0]) << (16 - FRAC_W);
    fy = 32'(sy[FRAC_W-1:0]) << (16 - FRAC_W);
    return lerp16(lerp16(smooth_val(cx, cy), smooth_val(cx + 1, cy), fx),
                  lerp16(smooth_val(cx, cy + 1), smooth_val(cx + 1, cy + 1), fx), fy);
  endfunction

  function automatic logic [63:0] coord_mag(input logic signed [COORD_W-1:0] v);
    return v[COORD_W-1] ? 64'(-$signed(65'(v))) : 64'(v);
  endfunction

  // weighted, normalized octave sum
  function automatic logic [16:0] noise_of(input point_t p);
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] total;
    logic [63:0] wsum;
    logic [63:0] amp;
    logic [63:0] q;
    int cnt;
    mx = coord_mag(p.x);
    my = coord_mag(p.y);
    cnt = octaves;
    if (cnt == 0) cnt = 1;
    if (cnt > MAX_OCT) cnt = MAX_OCT;
    total = 0;
    wsum = 0;
    amp = 65536;
    for (int i = 0; i < cnt; i++) begin
      total += 64'(octave_noise(mx, my, i)) * amp;
      wsum += amp;
      amp = (amp * persist_q16) >> 16;
    end
    q = total / wsum;
    if (q > 65536) q = 65536;
    return 17'(q);
  endfunction

  // driver: present points from the pending queue
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_pts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.pos_x <= pending_pts[0].x;
        in_ch.pos_y <= pending_pts[0].y;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // pop the queue on acceptance and record the expected result
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_noise.push_back(noise_of(pending_pts.pop_front()));
      accepted_pts++;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_noise.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result noise_value=%0d", out_ch.noise_value);
      end else begin
        logic [16:0] exp_v;
        exp_v = expected_noise.pop_front();
        if (out_ch.noise_value !== exp_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise_value mismatch: expected %0d actual %0d", exp_v,
                     out_ch.noise_value);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_pts.size() > 0 || expected_noise.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PERSISTENCE) persist_q16 = val;
    else octaves = val[3:0];
    // amplitude chain settling
    repeat (MAX_OCT + 4) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return COORD_W'($urandom_range(16383));
      1: return -COORD_W'($urandom_range(16383));
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int n);
    point_t p;
    for (int k = 0; k < n; k++) begin
      p.x = rand_coord();
      p.y = rand_coord();
      pending_pts.push_back(p);
    end
  endtask

  initial begin
    point_t p;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_PERSISTENCE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    out_ch.ready = 1'b0;
    persist_q16 = 16'd32768;
    octaves = 4'd4;
    mismatches = 0;
    cycles = 0;
    accepted_pts = 0;
    send_idle_pct = 7;
    recv_idle_pct = 86;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: coordinate extremes, zero, fractions, sign pairs
    p.x = '0; p.y = '0; pending_pts.push_back(p);
    p.x = {1'b1, {(COORD_W-1){1'b0}}}; p.y = {1'b0, {(COORD_W-1){1'b1}}};
    pending_pts.push_back(p);
    p.x = {1'b0, {(COORD_W-1){1'b1}}}; p.y = {1'b1, {(COORD_W-1){1'b0}}};
    pending_pts.push_back(p);
    p.x = '1; p.y = 24'sd1; pending_pts.push_back(p);
    p.x = 24'sd4095; p.y = -24'sd4096; pending_pts.push_back(p);
    p.x = 24'sd4096; p.y = 24'sd4095; pending_pts.push_back(p);
    p.x = 24'h555555; p.y = 24'haaaaaa; pending_pts.push_back(p);
    p.x = 24'haaaaaa; p.y = 24'h555555; pending_pts.push_back(p);
    wait_drained();

    // zero persistence: octave 0 only
    write_reg(CFG_PERSISTENCE, 16'd0);
    p.x = 24'sd12345; p.y = -24'sd777; pending_pts.push_back(p);
    p.x = {1'b1, {(COORD_W-1){1'b0}}}; p.y = '0; pending_pts.push_back(p);
    wait_drained();
    // zero octave count acts as one
    write_reg(CFG_PERSISTENCE, 16'hffff);
    write_reg(CFG_OCTAVE_COUNT, 16'd0);
    p.x = 24'sd9000; p.y = 24'sd3; pending_pts.push_back(p);
    wait_drained();
    // count above the maximum saturates
    write_reg(CFG_OCTAVE_COUNT, 16'd15);
    p.x = -24'sd9000; p.y = 24'sd81920; pending_pts.push_back(p);
    p.x = {1'b0, {(COORD_W-1){1'b1}}}; p.y = '1; pending_pts.push_back(p);
    wait_drained();
    write_reg(CFG_OCTAVE_COUNT, 16'd8);
    p.x = 24'sd1; p.y = 24'sd1; pending_pts.push_back(p);
    wait_drained();

    // random phases across settings and idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 7; recv_idle_pct = 86; end
        1: begin send_idle_pct = 86; recv_idle_pct = 7; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(CFG_PERSISTENCE, 16'($urandom));
      write_reg(CFG_OCTAVE_COUNT, 16'($urandom_range(1, 8)));
      queue_random(100);
      wait_drained();
    end

    if (mismatches == 0 && expected_noise.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
